/* hdl/tpa_pkg.sv */
package tpa_pkg;

	// Index range that the vertex fetch can address.
	localparam int INDEX_BITS = 32;
	localparam logic [32:0] INDEX_LIMIT = (33'd1 << INDEX_BITS) - 33'd1;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// Primitive modes.
	localparam logic [1:0] MODE_LIST  = 2'd0;
	localparam logic [1:0] MODE_STRIP = 2'd1;
	localparam logic [1:0] MODE_FAN   = 2'd2;
	localparam logic [1:0] MODE_BAD   = 2'd3;

	// Run status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BOUNDS   = 3'd1;
	localparam logic [2:0] ST_COUNT    = 3'd2;
	localparam logic [2:0] ST_MODE     = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	// Result kinds.
	localparam logic KIND_TRIANGLE = 1'b0;
	localparam logic KIND_STATUS   = 1'b1;

	// Configuration register indexes.
	localparam logic REG_PRIMITIVE_MODE = 1'b0;
	localparam logic REG_VERTEX_COUNT   = 1'b1;

	typedef struct packed {
		logic [31:0] vertex_index;
		logic        last_index;
	} tpa_in_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] corner_a;
		logic [31:0] corner_b;
		logic [31:0] corner_c;
		logic [2:0]  run_status;
		logic        run_end;
	} tpa_out_t;

	// One classified item: an optional triangle and an optional end-of-run status.
	typedef struct packed {
		logic        tri_valid;
		logic [31:0] corner_a;
		logic [31:0] corner_b;
		logic [31:0] corner_c;
		logic        end_valid;
		logic [2:0]  run_status;
	} tpa_job_t;

endpackage

/* hdl/tpa_front.sv */
module tpa_front
	import tpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  tpa_in_t     in_data,
	input  logic        queue_full,
	output logic        push,
	output tpa_job_t    push_job
);

	logic [1:0]  mode_q;
	logic [31:0] vertex_count_q;
	logic [31:0] fan_origin_q;
	logic [31:0] older_q;
	logic [31:0] newer_q;
	logic [31:0] pos_count_q;
	logic [1:0]  phase_q;
	logic [2:0]  first_err_q;

	logic        accept;
	logic [31:0] idx;
	logic        p_max;
	logic        p_ge2;
	logic        idx_bad;
	logic [2:0]  err_next;
	logic        ok;
	logic [1:0]  phase_next;
	logic [2:0]  final_status;
	logic        tri_valid;
	logic [31:0] tri_a;
	logic [31:0] tri_b;

	assign in_ready = !queue_full;
	assign accept = in_valid && in_ready;
	assign idx = in_data.vertex_index;

	// Classify the incoming index against the run state.
	assign p_max = (pos_count_q == 32'hFFFF_FFFF);
	assign p_ge2 = |pos_count_q[31:1];
	assign idx_bad = ({1'b0, idx} > INDEX_LIMIT) || (idx >= vertex_count_q);
	assign phase_next = p_max ? phase_q : ((phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1);

	always_comb begin
		err_next = first_err_q;
		if (first_err_q == ST_OK) begin
			if (p_max) begin
				err_next = ST_OVERFLOW;
			end else if (idx_bad) begin
				err_next = ST_BOUNDS;
			end
		end
	end

	assign ok = (err_next == ST_OK);

	// Status reported when this index closes the run.
	always_comb begin
		final_status = err_next;
		if (err_next == ST_OK) begin
			if (mode_q == MODE_BAD) begin
				final_status = ST_MODE;
			end else if (mode_q == MODE_LIST && phase_next != 2'd0) begin
				final_status = ST_COUNT;
			end
		end
	end

	// Triangle selection per primitive mode.
	always_comb begin
		tri_valid = 1'b0;
		tri_a = older_q;
		tri_b = newer_q;
		case (mode_q)
			MODE_LIST: begin
				tri_valid = ok && (phase_q == 2'd2);
			end
			MODE_STRIP: begin
				tri_valid = ok && p_ge2;
				if (pos_count_q[0]) begin
					tri_a = newer_q;
					tri_b = older_q;
				end
			end
			MODE_FAN: begin
				tri_valid = ok && p_ge2;
				tri_a = fan_origin_q;
			end
			default: begin
				tri_valid = 1'b0;
			end
		endcase
	end

	assign push = accept && (tri_valid || in_data.last_index);
	assign push_job = '{
		tri_valid:  tri_valid,
		corner_a:   tri_a,
		corner_b:   tri_b,
		corner_c:   idx,
		end_valid:  in_data.last_index,
		run_status: final_status
	};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LIST;
			vertex_count_q <= 32'd1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PRIMITIVE_MODE: mode_q <= cfg_data[1:0];
				REG_VERTEX_COUNT: vertex_count_q <= cfg_data;
				default: mode_q <= mode_q;
			endcase
		end
	end

	// Run state, cleared after the last index of each run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_origin_q <= '0;
			older_q <= '0;
			newer_q <= '0;
			pos_count_q <= '0;
			phase_q <= '0;
			first_err_q <= ST_OK;
		end else if (accept) begin
			if (in_data.last_index) begin
				fan_origin_q <= '0;
				older_q <= '0;
				newer_q <= '0;
				pos_count_q <= '0;
				phase_q <= '0;
				first_err_q <= ST_OK;
			end else begin
				first_err_q <= err_next;
				phase_q <= phase_next;
				if (!p_max) begin
					pos_count_q <= pos_count_q + 32'd1;
				end
				if (pos_count_q == 32'd0) begin
					fan_origin_q <= idx;
				end
				if (mode_q == MODE_LIST) begin
					if (phase_q == 2'd0) begin
						older_q <= idx;
					end else if (phase_q == 2'd1) begin
						newer_q <= idx;
					end
				end else if (mode_q != MODE_BAD) begin
					older_q <= newer_q;
					newer_q <= idx;
				end
			end
		end
	end

endmodule

/* hdl/tpa_queue.sv */
module tpa_queue
	import tpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tpa_job_t push_job,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output tpa_job_t head_job
);

	tpa_job_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

endmodule

/* hdl/tpa_back.sv */
module tpa_back
	import tpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  tpa_job_t head_job,
	output logic     pop,
	output logic     out_valid,
	input  logic     out_ready,
	output tpa_out_t out_data
);

	logic     out_valid_q;
	tpa_out_t out_data_q;
	logic     tri_done_q;

	logic     load;
	logic     take_tri;
	logic     tri_done_next;
	tpa_out_t next_out;

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign load = !out_valid_q || out_ready;

	// Send the triangle first, then the status, popping after the last result.
	assign take_tri = head_job.tri_valid && !tri_done_q;

	always_comb begin
		pop = 1'b0;
		tri_done_next = tri_done_q;
		if (take_tri) begin
			next_out = '{
				result_kind: KIND_TRIANGLE,
				corner_a:    head_job.corner_a,
				corner_b:    head_job.corner_b,
				corner_c:    head_job.corner_c,
				run_status:  ST_OK,
				run_end:     1'b0
			};
		end else begin
			next_out = '{
				result_kind: KIND_STATUS,
				corner_a:    32'd0,
				corner_b:    32'd0,
				corner_c:    32'd0,
				run_status:  head_job.run_status,
				run_end:     1'b1
			};
		end
		if (load && head_valid) begin
			if (take_tri && head_job.end_valid) begin
				tri_done_next = 1'b1;
			end else begin
				pop = 1'b1;
				tri_done_next = 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tri_done_q <= 1'b0;
		end else begin
			tri_done_q <= tri_done_next;
			if (load) begin
				out_valid_q <= head_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_data_q <= next_out;
		end
	end

endmodule

/* hdl/triangle_primitive_assembler_unit.sv */
// Triangle primitive assembler.
// Input channel (in_valid/in_ready/in_data) takes one vertex index per
// transaction, with last_index marking the final index of a run. Output
// channel (out_valid/out_ready/out_data) gives triangle results and, after
// the last index of each run, one status result with run_end set.
// Configuration: cfg_write writes cfg_data into the register at cfg_index
// (0 primitive mode, 1 vertex count); write only while the block is idle.
// The front classifies one index per cycle with the run state while the
// queue is not full; a four-entry queue decouples it from the back, which
// owns the output register. An accepted index is written into the queue,
// and its first result then passes from the queue head into the output
// register. An index that yields both a triangle and a status gives the
// triangle first, then the status. When the receiver stalls, results wait
// in the output register and the queue; in_ready drops only when the
// queue is full. Reset sets list mode, a vertex count of one, clears the
// run state and empties the queue and the output register.
module triangle_primitive_assembler_unit
	import tpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  tpa_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output tpa_out_t    out_data
);

	logic     queue_full;
	logic     push;
	tpa_job_t push_job;
	logic     pop;
	logic     head_valid;
	tpa_job_t head_job;

	tpa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	tpa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	tpa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
